>>> rtl/resolution_bitrate_band_check_macros.svh
// assertion macros shared by the band check rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef RESOLUTION_BITRATE_BAND_CHECK_MACROS_SVH
`define RESOLUTION_BITRATE_BAND_CHECK_MACROS_SVH

// same-cycle implication
`define RBBC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbbc assertion failed");

// implication after a fixed number of cycles
`define RBBC_ASSERT_DLY(label, ante, n, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("rbbc delayed assertion failed");

`endif

>>> rtl/rbbc_pkg.sv
// types and constant tables of the resolution bitrate band check
// no dependencies; used by rbbc_interp and the top level

package rbbc_pkg;

  localparam int unsigned NUM_BAND = 7;
  localparam int unsigned NUM_SEG  = 6;
  localparam int unsigned LANE_LAT = 4;

  localparam longint unsigned RECIP_ONE = 64'd1 << 32;

  typedef enum logic [1:0] {
    VERDICT_INSUFF = 2'd0,
    VERDICT_NORMAL = 2'd1,
    VERDICT_ABOVE  = 2'd2,
    VERDICT_BELOW  = 2'd3
  } rbbc_verdict_e;

  // slope of one bound over one segment as n/d, m = floor(2^32 / d)
  typedef struct packed {
    logic [9:0]  n;
    logic [7:0]  d;
    logic [29:0] m;
    logic [21:0] base;
  } rbbc_seg_t;

  localparam logic [27:0] BAND_AREA [NUM_BAND] = '{
    28'd0, 28'd57600, 28'd129600, 28'd230400, 28'd518400, 28'd921600, 28'd2073600
  };
  localparam logic [21:0] BAND_MIN [NUM_BAND] = '{
    22'd0, 22'd0, 22'd300000, 22'd500000, 22'd800000, 22'd1500000, 22'd2500000
  };
  localparam logic [21:0] BAND_MAX [NUM_BAND] = '{
    22'd0, 22'd300000, 22'd500000, 22'd800000, 22'd1500000, 22'd2500000, 22'd4000000
  };

  // slopes reduced from (y2 - y1) / (x2 - x1) of each segment
  localparam logic [9:0] LO_N [NUM_SEG] = '{10'd0, 10'd25, 10'd125, 10'd25, 10'd125, 10'd125};
  localparam logic [7:0] LO_D [NUM_SEG] = '{8'd6, 8'd6, 8'd63, 8'd24, 8'd72, 8'd144};
  localparam logic [9:0] HI_N [NUM_SEG] = '{10'd125, 10'd25, 10'd125, 10'd175, 10'd625, 10'd125};
  localparam logic [7:0] HI_D [NUM_SEG] = '{8'd24, 8'd9, 8'd42, 8'd72, 8'd252, 8'd96};

  localparam logic [29:0] LO_M [NUM_SEG] = '{
    30'(RECIP_ONE / 64'd6),  30'(RECIP_ONE / 64'd6),  30'(RECIP_ONE / 64'd63),
    30'(RECIP_ONE / 64'd24), 30'(RECIP_ONE / 64'd72), 30'(RECIP_ONE / 64'd144)
  };
  localparam logic [29:0] HI_M [NUM_SEG] = '{
    30'(RECIP_ONE / 64'd24), 30'(RECIP_ONE / 64'd9),   30'(RECIP_ONE / 64'd42),
    30'(RECIP_ONE / 64'd72), 30'(RECIP_ONE / 64'd252), 30'(RECIP_ONE / 64'd96)
  };

endpackage

>>> rtl/rbbc_interp.sv
// one interpolation lane: base + floor(n * dx / d) in four stages
// depends on rbbc_pkg and the shared assertion macros

`include "resolution_bitrate_band_check_macros.svh"

module rbbc_interp import rbbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  rbbc_seg_t   in_seg_i,
  input  logic [20:0] in_dx_i,
  output logic        out_valid_o,
  output logic [21:0] out_value_o
);

  logic [3:0]  valid_q;
  // stage 1: product
  logic [27:0] p1_q;
  rbbc_seg_t   seg1_q;
  // stage 2: quotient estimate
  logic [57:0] t2_d;
  logic [27:0] p2_q;
  logic [20:0] q2_q;
  logic [7:0]  d2_q;
  logic [21:0] base2_q;
  // stage 3: remainder
  logic [28:0] qd3_d;
  logic [27:0] r3_d;
  logic [8:0]  r3_q;
  logic [20:0] q3_q;
  logic [7:0]  d3_q;
  logic [21:0] base3_q;
  // stage 4: corrected value
  logic [20:0] q4_d;
  logic [21:0] val4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], in_valid_i};
    end
  end

  always_comb begin
    t2_d  = 58'(p1_q) * 58'(seg1_q.m);
    qd3_d = 29'(q2_q) * 29'(d2_q);
    r3_d  = p2_q - qd3_d[27:0];
    // estimate is short by at most one
    q4_d  = (r3_q >= {1'b0, d3_q}) ? q3_q + 21'd1 : q3_q;
  end

  always_ff @(posedge clk_i) begin
    p1_q    <= 28'(in_seg_i.n) * 28'(in_dx_i);
    seg1_q  <= in_seg_i;
    p2_q    <= p1_q;
    q2_q    <= t2_d[52:32];
    d2_q    <= seg1_q.d;
    base2_q <= seg1_q.base;
    r3_q    <= r3_d[8:0];
    q3_q    <= q2_q;
    d3_q    <= d2_q;
    base3_q <= base2_q;
    val4_q  <= base3_q + 22'(q4_d);
  end

  assign out_valid_o = valid_q[3];
  assign out_value_o = val4_q;

  `RBBC_ASSERT_IMP(a_rem_below_twice_d, valid_q[2], r3_q < {d3_q, 1'b0})
  `RBBC_ASSERT_DLY(a_lane_latency, in_valid_i, 4, out_valid_o)
  `RBBC_ASSERT_DLY(a_flat_keeps_base, in_valid_i && in_seg_i.n == 10'd0, 4,
                   out_value_o == $past(in_seg_i.base, 4))

endmodule

>>> rtl/resolution_bitrate_band_check.sv
// resolution bitrate band check, top level
// depends on rbbc_pkg, rbbc_interp and the shared assertion macros
//
// Usage: an item (frame_width_i, frame_height_i, average_bitrate_i,
// sample_valid_i) is taken at each rising edge with start high and busy
// low. busy never rises, so an item may be given in every cycle.
// Each item gives one result (verdict_o, min_bitrate_o, max_bitrate_o)
// shown for one cycle with result_valid_o high, in item order. Each item
// passes these registered stages: area multiply, breakpoint select, four
// interpolation stages (slope multiply, reciprocal multiply, remainder,
// correction) and the verdict register.
// Throughput is one item per cycle.
// Min and max bounds run in two parallel lanes.
// Reset clears all valid bits; items in flight are dropped. The receiver
// cannot stall, so results are never held back.

`include "resolution_bitrate_band_check_macros.svh"

module resolution_bitrate_band_check import rbbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [13:0] frame_width_i,
  input  logic [13:0] frame_height_i,
  input  logic [31:0] average_bitrate_i,
  input  logic        sample_valid_i,
  output logic        result_valid_o,
  output logic [1:0]  verdict_o,
  output logic [21:0] min_bitrate_o,
  output logic [21:0] max_bitrate_o
);

  // accepting edge to the edge that takes the result
  localparam int unsigned TOTAL_LAT = LANE_LAT + 3;

  logic accept;

  // stage 1: area
  logic        v1_q;
  logic        insuff1_q;
  logic [27:0] area1_q;
  logic [31:0] rate1_q;

  // stage 2: breakpoint select
  logic [2:0]  sel_d;
  logic [2:0]  seg_idx;
  logic [27:0] dx_full;
  rbbc_seg_t   lo_seg_d, hi_seg_d;
  logic        v2_q;
  rbbc_seg_t   lo_seg_q, hi_seg_q;
  logic [20:0] dx_q;
  logic        insuff2_q;
  logic [31:0] rate2_q;

  // side line matched to the lanes
  logic        insuff_dl_q [LANE_LAT];
  logic [31:0] rate_dl_q   [LANE_LAT];

  logic        lo_valid, hi_valid;
  logic [21:0] lo_value, hi_value;

  logic          out_valid_q;
  rbbc_verdict_e verdict_d, verdict_q;
  logic [21:0]   min_d, max_d, min_q, max_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      out_valid_q <= lo_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    area1_q   <= 28'(frame_width_i) * 28'(frame_height_i);
    insuff1_q <= !sample_valid_i || frame_width_i == 14'd0 || frame_height_i == 14'd0;
    rate1_q   <= average_bitrate_i;
  end

  // last breakpoint not above the area; the area is never zero when used
  always_comb begin
    sel_d = 3'd0;
    for (int k = 1; k < NUM_BAND; k++) begin
      if (area1_q >= BAND_AREA[k]) begin
        sel_d = 3'(k);
      end
    end
    seg_idx = (sel_d == 3'(NUM_SEG)) ? 3'(NUM_SEG - 1) : sel_d;
    dx_full = area1_q - BAND_AREA[sel_d];

    lo_seg_d.n    = LO_N[seg_idx];
    lo_seg_d.d    = LO_D[seg_idx];
    lo_seg_d.m    = LO_M[seg_idx];
    lo_seg_d.base = BAND_MIN[sel_d];
    hi_seg_d.n    = HI_N[seg_idx];
    hi_seg_d.d    = HI_D[seg_idx];
    hi_seg_d.m    = HI_M[seg_idx];
    hi_seg_d.base = BAND_MAX[sel_d];
    // at or above the last breakpoint the band is flat
    if (sel_d == 3'(NUM_SEG)) begin
      lo_seg_d.n = '0;
      hi_seg_d.n = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_seg_q  <= lo_seg_d;
    hi_seg_q  <= hi_seg_d;
    dx_q      <= (sel_d == 3'(NUM_SEG)) ? 21'd0 : dx_full[20:0];
    insuff2_q <= insuff1_q;
    rate2_q   <= rate1_q;
  end

  always_ff @(posedge clk_i) begin
    insuff_dl_q[0] <= insuff2_q;
    rate_dl_q[0]   <= rate2_q;
    for (int k = 1; k < LANE_LAT; k++) begin
      insuff_dl_q[k] <= insuff_dl_q[k-1];
      rate_dl_q[k]   <= rate_dl_q[k-1];
    end
  end

  rbbc_interp u_lo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2_q),
    .in_seg_i    (lo_seg_q),
    .in_dx_i     (dx_q),
    .out_valid_o (lo_valid),
    .out_value_o (lo_value)
  );

  rbbc_interp u_hi (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2_q),
    .in_seg_i    (hi_seg_q),
    .in_dx_i     (dx_q),
    .out_valid_o (hi_valid),
    .out_value_o (hi_value)
  );

  always_comb begin
    min_d     = lo_value;
    max_d     = hi_value;
    verdict_d = VERDICT_NORMAL;
    if (insuff_dl_q[LANE_LAT-1]) begin
      min_d     = '0;
      max_d     = '0;
      verdict_d = VERDICT_INSUFF;
    end else if (rate_dl_q[LANE_LAT-1] > 32'(hi_value)) begin
      verdict_d = VERDICT_ABOVE;
    end else if (rate_dl_q[LANE_LAT-1] < 32'(lo_value)) begin
      verdict_d = VERDICT_BELOW;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    min_q     <= min_d;
    max_q     <= max_d;
  end

  assign result_valid_o = out_valid_q;
  assign verdict_o      = verdict_q;
  assign min_bitrate_o  = min_q;
  assign max_bitrate_o  = max_q;

  `RBBC_ASSERT_IMP(a_lanes_aligned, lo_valid || hi_valid, lo_valid && hi_valid)
  `RBBC_ASSERT_IMP(a_band_ordered, result_valid_o, min_bitrate_o <= max_bitrate_o)
  `RBBC_ASSERT_IMP(a_insuff_zero_band, result_valid_o && verdict_o == VERDICT_INSUFF,
                   min_bitrate_o == 22'd0 && max_bitrate_o == 22'd0)
  `RBBC_ASSERT_DLY(a_item_latency, accept, TOTAL_LAT, result_valid_o)

endmodule

>>> bench/testbench.sv
// self-checking testbench of resolution_bitrate_band_check
// needs rbbc_pkg and the band check rtl; area, band and verdict are predicted here
`timescale 1ns / 1ps

module testbench;
  import rbbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_WAIT  = 24;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned NUM_PT       = 7;

  // breakpoints: area, band min, band max
  localparam logic [27:0] AREA_PT [NUM_PT] = '{
    28'd0, 28'd57600, 28'd129600, 28'd230400, 28'd518400, 28'd921600, 28'd2073600
  };
  localparam logic [21:0] MIN_PT [NUM_PT] = '{
    22'd0, 22'd0, 22'd300000, 22'd500000, 22'd800000, 22'd1500000, 22'd2500000
  };
  localparam logic [21:0] MAX_PT [NUM_PT] = '{
    22'd0, 22'd300000, 22'd500000, 22'd800000, 22'd1500000, 22'd2500000, 22'd4000000
  };
  localparam logic [13:0] PT_WIDTH  [NUM_PT] = '{14'd0, 14'd320, 14'd480, 14'd640, 14'd960,
                                                 14'd1280, 14'd1920};
  localparam logic [13:0] PT_HEIGHT [NUM_PT] = '{14'd0, 14'd180, 14'd270, 14'd360, 14'd540,
                                                 14'd720, 14'd1080};

  typedef struct {
    logic [13:0] width;
    logic [13:0] height;
    logic [31:0] rate;
    logic        valid;
    bit          pause;
    int unsigned idle_pct;
  } band_query_t;

  typedef struct {
    rbbc_verdict_e verdict;
    logic [21:0]   lo;
    logic [21:0]   hi;
  } band_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start             = 1'b0;
  logic        busy;
  logic [13:0] frame_width_i     = '0;
  logic [13:0] frame_height_i    = '0;
  logic [31:0] average_bitrate_i = '0;
  logic        sample_valid_i    = 1'b0;
  logic        result_valid_o;
  logic [1:0]  verdict_o;
  logic [21:0] min_bitrate_o;
  logic [21:0] max_bitrate_o;

  band_query_t  queries_q [$];
  band_result_t pending_bands_q [$];
  band_result_t want;
  logic         item_taken;
  int unsigned  mismatch_count   = 0;
  int unsigned  verdict_tally [4] = '{default: 0};
  int unsigned  cycle_count      = 0;

  resolution_bitrate_band_check i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .frame_width_i     (frame_width_i),
    .frame_height_i    (frame_height_i),
    .average_bitrate_i (average_bitrate_i),
    .sample_valid_i    (sample_valid_i),
    .result_valid_o    (result_valid_o),
    .verdict_o         (verdict_o),
    .min_bitrate_o     (min_bitrate_o),
    .max_bitrate_o     (max_bitrate_o)
  );

  function automatic logic [21:0] lerp_bound(input longint unsigned x1, input longint unsigned y1,
                                             input longint unsigned x2, input longint unsigned y2,
                                             input longint unsigned x);
    return 22'(y1 + ((y2 - y1) * (x - x1)) / (x2 - x1));
  endfunction

  function automatic band_result_t classify_rate(input logic [13:0] w, input logic [13:0] h,
                                                 input logic [31:0] rate, input logic valid);
    band_result_t r;
    logic [27:0]  area;
    int           seg;
    r = '{verdict: VERDICT_INSUFF, lo: '0, hi: '0};
    if (!valid || w == 0 || h == 0) return r;
    area = w * h;
    seg = NUM_PT;
    for (int i = NUM_PT - 1; i >= 0; i--) begin
      if (AREA_PT[i] >= area) seg = i;
    end
    if (seg == NUM_PT) begin
      r.lo = MIN_PT[NUM_PT-1];
      r.hi = MAX_PT[NUM_PT-1];
    end else if (AREA_PT[seg] == area || seg == 0) begin
      r.lo = MIN_PT[seg];
      r.hi = MAX_PT[seg];
    end else begin
      r.lo = lerp_bound(AREA_PT[seg-1], MIN_PT[seg-1], AREA_PT[seg], MIN_PT[seg], area);
      r.hi = lerp_bound(AREA_PT[seg-1], MAX_PT[seg-1], AREA_PT[seg], MAX_PT[seg], area);
      if (r.hi < r.lo) return '{verdict: VERDICT_INSUFF, lo: '0, hi: '0};
    end
    if (rate > r.hi) r.verdict = VERDICT_ABOVE;
    else if (rate < r.lo) r.verdict = VERDICT_BELOW;
    else r.verdict = VERDICT_NORMAL;
    return r;
  endfunction

  task automatic push_query(input logic [13:0] w, input logic [13:0] h, input logic [31:0] rate,
                            input logic valid, input int unsigned idle_pct);
    queries_q.push_back('{width: w, height: h, rate: rate, valid: valid, pause: 1'b0,
                          idle_pct: idle_pct});
  endtask

  // sender holds off until every outstanding result is back
  task automatic push_pause();
    queries_q.push_back('{width: '0, height: '0, rate: '0, valid: 1'b0, pause: 1'b1,
                          idle_pct: 0});
  endtask

  task automatic push_random_query(input int unsigned idle_pct);
    logic [13:0]  w;
    logic [13:0]  h;
    logic [31:0]  rate;
    logic         valid;
    band_result_t band;
    int unsigned  pick;
    int unsigned  pt;
    valid = 1'b1;
    pick = $urandom_range(99);
    if (pick < 8) begin
      w = 14'($urandom);
      h = 14'($urandom);
      valid = 1'b0;
    end else if (pick < 14) begin
      w = 14'($urandom);
      h = 14'($urandom);
      if ($urandom_range(1)) w = '0;
      else h = '0;
    end else if (pick < 26) begin
      w = 14'($urandom);
      h = 14'($urandom);
    end else if (pick < 46) begin
      // straddle a breakpoint
      pt = $urandom_range(NUM_PT - 1, 1);
      w = PT_WIDTH[pt] + 14'($urandom_range(4)) - 14'd2;
      h = PT_HEIGHT[pt] + 14'($urandom_range(2)) - 14'd1;
    end else begin
      w = 14'($urandom_range(2200, 1));
      h = 14'($urandom_range(1300, 1));
    end
    band = classify_rate(w, h, '0, valid);
    pick = $urandom_range(99);
    if (pick < 15) begin
      rate = $urandom;
    end else if (pick < 30) begin
      case ($urandom_range(5))
        0: rate = '0;
        1: rate = '1;
        2: rate = 32'(band.lo);
        3: rate = 32'(band.hi);
        4: rate = 32'(band.lo) - 32'd1;
        default: rate = 32'(band.hi) + 32'd1;
      endcase
    end else begin
      rate = $urandom_range(32'(band.hi) + 32'(band.hi) / 4 + 1,
                            32'(band.lo) - 32'(band.lo) / 4);
    end
    push_query(w, h, rate, valid, idle_pct);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: inputs move on the falling edge only
  always @(negedge clk_i) begin
    if (rst_ni && (!start || item_taken)) begin
      if (queries_q.size() == 0) begin
        start <= 1'b0;
      end else if (queries_q[0].pause) begin
        start <= 1'b0;
        if (!start && pending_bands_q.size() == 0) void'(queries_q.pop_front());
      end else if ($urandom_range(99) < queries_q[0].idle_pct) begin
        start <= 1'b0;
      end else begin
        frame_width_i     <= queries_q[0].width;
        frame_height_i    <= queries_q[0].height;
        average_bitrate_i <= queries_q[0].rate;
        sample_valid_i    <= queries_q[0].valid;
        start             <= 1'b1;
        void'(queries_q.pop_front());
      end
    end
  end

  // monitor: check results first, then record the item taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_taken <= 1'b0;
    end else begin
      if (result_valid_o) begin
        if (pending_bands_q.size() == 0) begin
          $error("result with none expected: verdict %0d min %0d max %0d",
                 verdict_o, min_bitrate_o, max_bitrate_o);
          mismatch_count++;
        end else begin
          want = pending_bands_q.pop_front();
          verdict_tally[want.verdict]++;
          if (verdict_o !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, verdict_o);
            mismatch_count++;
          end
          if (min_bitrate_o !== want.lo) begin
            $error("min_bitrate: expected %0d, got %0d", want.lo, min_bitrate_o);
            mismatch_count++;
          end
          if (max_bitrate_o !== want.hi) begin
            $error("max_bitrate: expected %0d, got %0d", want.hi, max_bitrate_o);
            mismatch_count++;
          end
        end
      end
      item_taken <= start && !busy;
      if (start && !busy) begin
        pending_bands_q.push_back(classify_rate(frame_width_i, frame_height_i,
                                                average_bitrate_i, sample_valid_i));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;

    // zero dimensions and missing samples
    push_query(14'd0, 14'd100, 32'd1000, 1'b1, 29);
    push_query(14'd100, 14'd0, 32'd1000, 1'b1, 29);
    push_query(14'd0, 14'd0, 32'hFFFF_FFFF, 1'b0, 29);
    push_query(14'h3FFF, 14'h3FFF, 32'hFFFF_FFFF, 1'b0, 29);
    // smallest area, interpolated from the origin
    push_query(14'd1, 14'd1, 32'd0, 1'b1, 29);
    push_query(14'd1, 14'd1, 32'hFFFF_FFFF, 1'b1, 29);
    // exact breakpoints, rate on and just past the band edges
    push_query(14'd320, 14'd180, 32'd300000, 1'b1, 29);
    push_query(14'd320, 14'd180, 32'd300001, 1'b1, 29);
    push_query(14'd480, 14'd270, 32'd299999, 1'b1, 29);
    push_query(14'd480, 14'd270, 32'd300000, 1'b1, 29);
    push_query(14'd640, 14'd360, 32'd800000, 1'b1, 29);
    push_query(14'd960, 14'd540, 32'd799999, 1'b1, 29);
    push_query(14'd1280, 14'd720, 32'd2500001, 1'b1, 29);
    push_query(14'd1920, 14'd1080, 32'd2500000, 1'b1, 29);
    push_query(14'd1920, 14'd1080, 32'd4000001, 1'b1, 29);
    // above the last breakpoint
    push_query(14'd1921, 14'd1080, 32'd4000000, 1'b1, 29);
    push_query(14'h3FFF, 14'h3FFF, 32'd0, 1'b1, 29);
    push_query(14'h3FFF, 14'h3FFF, 32'hFFFF_FFFF, 1'b1, 29);
    // between breakpoints, and two areas above the last breakpoint
    push_query(14'd400, 14'd200, 32'd150000, 1'b1, 29);
    push_query(14'd320, 14'd181, 32'd300000, 1'b1, 29);
    push_query(14'd1919, 14'd1080, 32'd0, 1'b1, 29);
    push_query(14'd8191, 14'd1, 32'd123456, 1'b1, 29);
    push_query(14'd2730, 14'd5461, 32'h8000_0000, 1'b1, 29);
    push_query(14'd5461, 14'd2730, 32'h7FFF_FFFF, 1'b1, 29);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) push_pause();
      push_random_query(n < RANDOM_ITEMS / 3 ? 29 : (n < 2 * RANDOM_ITEMS / 3 ? 46 : 0));
    end

    repeat (6) @(posedge clk_i);
    #2 rst_ni = 1'b1;

    while (queries_q.size() != 0 || start || pending_bands_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_WAIT) @(negedge clk_i);

    $display("checked %0d results: %0d insufficient, %0d normal, %0d above band, %0d below band",
             verdict_tally[0] + verdict_tally[1] + verdict_tally[2] + verdict_tally[3],
             verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3]);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
